/* src/qse_pkg.sv */
package qse_pkg;

    localparam int MAX_KNOTS_DEF   = 64;
    localparam int COEFF_WIDTH_DEF = 48;

    localparam int ACT_W      = 2;
    localparam int IDX_W      = 6;
    localparam int SEL_W      = 3;
    localparam int KC_W       = 7;
    localparam int KNOT_W     = 32;
    localparam int RES_W      = 48;
    localparam int D_W        = KNOT_W + 1;
    localparam int NUM_COEFFS = 6;
    localparam int TOP_COEFF  = NUM_COEFFS - 1;
    localparam int FRAC_SHIFT = 16;
    localparam int KC_RESET   = 2;

    localparam logic [ACT_W-1:0] ACT_WR_KNOT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_COEF = 2'd1;
    localparam logic [ACT_W-1:0] ACT_VALUE   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SLOPE   = 2'd3;

    typedef logic [1:0] t_knot_addr;
    localparam t_knot_addr KA_FIRST = 2'd0;
    localparam t_knot_addr KA_LAST  = 2'd1;
    localparam t_knot_addr KA_MID   = 2'd2;
    localparam t_knot_addr KA_SEG   = 2'd3;

    typedef logic [1:0] t_seg_sel;
    localparam t_seg_sel SEG_ZERO = 2'd0;
    localparam t_seg_sel SEG_LAST = 2'd1;
    localparam t_seg_sel SEG_LO   = 2'd2;

    typedef struct packed {
        logic       wr_knot;
        logic       wr_coef;
        logic       load_query;
        logic       knot_rd;
        t_knot_addr knot_addr;
        logic       init_bounds;
        logic       set_mid;
        logic       update_bounds;
        logic       set_seg;
        t_seg_sel   seg_sel;
        logic       coef_rd;
        logic       init_acc;
        logic       dec_k;
        logic       mag;
        logic       mul_lo;
        logic       mul_hi;
        logic       rnd;
        logic       add;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic x_le_kd;
        logic x_ge_kd;
        logic span_gt1;
        logic last_step;
    } t_dp_sts;

endpackage

/* src/qse_datapath.sv */
module qse_datapath #(
    parameter int MAX_KNOTS   = qse_pkg::MAX_KNOTS_DEF,
    parameter int COEFF_WIDTH = qse_pkg::COEFF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qse_pkg::t_dp_cmd                  i_cmd,
    output qse_pkg::t_dp_sts                  o_sts,
    input  logic [qse_pkg::ACT_W-1:0]         i_action,
    input  logic [qse_pkg::IDX_W-1:0]         i_entry_index,
    input  logic [qse_pkg::SEL_W-1:0]         i_coeff_sel,
    input  logic signed [qse_pkg::RES_W-1:0]  i_write_value,
    input  logic signed [qse_pkg::KNOT_W-1:0] i_query_x,
    input  logic                              i_cfg_wr_en,
    input  logic [qse_pkg::KC_W-1:0]          i_cfg_wr_data,
    output logic signed [qse_pkg::RES_W-1:0]  o_result_value,
    output logic [qse_pkg::IDX_W-1:0]         o_segment,
    output logic                              o_saturated
);

    localparam int KW     = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
    localparam int CDEPTH = (MAX_KNOTS - 1) * qse_pkg::NUM_COEFFS;
    localparam int CAW    = (CDEPTH > 2) ? $clog2(CDEPTH) : 1;
    localparam int RW     = qse_pkg::RES_W;
    localparam int HW     = RW / 2;
    localparam int DW     = qse_pkg::D_W;
    localparam int PP_W   = HW + DW;
    localparam int SUM_W  = RW + DW;
    localparam int SH_W   = SUM_W - qse_pkg::FRAC_SHIFT;
    localparam int SW     = RW + 4;
    localparam int IW     = qse_pkg::IDX_W;
    localparam int KNW    = qse_pkg::KNOT_W;
    localparam int SELW   = qse_pkg::SEL_W;
    localparam logic [SUM_W-1:0] RND_BIAS = SUM_W'(1) << (qse_pkg::FRAC_SHIFT - 1);

    logic signed [KNW-1:0]         r_knot_mem [MAX_KNOTS];
    logic signed [COEFF_WIDTH-1:0] r_coef_mem [CDEPTH];

    logic [qse_pkg::KC_W-1:0]  r_knot_count;
    logic signed [KNW-1:0]     r_x;
    logic                      r_slope;
    logic signed [KNW-1:0]     r_kd;
    logic signed [COEFF_WIDTH-1:0] r_cd;
    logic [KW-1:0]             r_lo;
    logic [KW-1:0]             r_hi;
    logic [KW-1:0]             r_mid;
    logic [KW-1:0]             r_seg;
    logic [SELW-1:0]           r_k;
    logic signed [DW-1:0]      r_d;
    logic signed [RW-1:0]      r_acc;
    logic                      r_flag;
    logic [RW-1:0]             r_amag;
    logic [DW-1:0]             r_dmag;
    logic                      r_neg;
    logic [PP_W-1:0]           r_pp_lo;
    logic [PP_W-1:0]           r_pp_hi;
    logic [RW-1:0]             r_pmag;
    logic signed [SW-1:0]      r_term;

    int                        kc_clamped;
    logic [KW-1:0]             last_idx;
    logic [KW-1:0]             mid;
    logic [KW-1:0]             knot_addr;
    logic [CAW-1:0]            coef_wr_addr;
    logic [CAW-1:0]            coef_rd_addr;
    logic                      knot_wr_ok;
    logic                      coef_wr_ok;
    logic signed [RW-1:0]      coef48;
    logic signed [SW-1:0]      coef_ext;
    logic signed [SW-1:0]      five_c;
    logic signed [SW-1:0]      term;
    logic [HW-1:0]             mul_a;
    logic [PP_W-1:0]           prod;
    logic [SUM_W-1:0]          full;
    logic [SH_W-1:0]           shifted;
    logic [SH_W-1:0]           limit;
    logic                      mul_over;
    logic signed [SW-1:0]      sum;
    logic                      five_fits;
    logic                      sum_fits;
    logic signed [RW-1:0]      res_max;
    logic signed [RW-1:0]      res_min;

    // clamp knot count to 2..MAX_KNOTS
    always_comb begin
        kc_clamped = int'(r_knot_count);
        if (kc_clamped < 2) begin
            kc_clamped = 2;
        end
        if (kc_clamped > MAX_KNOTS) begin
            kc_clamped = MAX_KNOTS;
        end
        last_idx = KW'(kc_clamped - 1);
    end

    assign mid = KW'(((KW + 1)'(r_lo) + (KW + 1)'(r_hi)) >> 1);

    always_comb begin
        case (i_cmd.knot_addr)
            qse_pkg::KA_FIRST: knot_addr = '0;
            qse_pkg::KA_LAST:  knot_addr = last_idx;
            qse_pkg::KA_MID:   knot_addr = mid;
            qse_pkg::KA_SEG:   knot_addr = r_seg;
            default:           knot_addr = r_seg;
        endcase
    end

    assign knot_wr_ok   = int'(i_entry_index) < MAX_KNOTS;
    assign coef_wr_ok   = (int'(i_entry_index) < MAX_KNOTS - 1) &&
                          (int'(i_coeff_sel) <= qse_pkg::TOP_COEFF);
    assign coef_wr_addr = CAW'(int'(i_entry_index) * qse_pkg::NUM_COEFFS + int'(i_coeff_sel));
    assign coef_rd_addr = CAW'(int'(r_seg) * qse_pkg::NUM_COEFFS + int'(r_k));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_knot && knot_wr_ok) begin
            r_knot_mem[KW'(i_entry_index)] <= i_write_value[KNW-1:0];
        end
        if (i_cmd.knot_rd) begin
            r_kd <= r_knot_mem[knot_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef && coef_wr_ok) begin
            r_coef_mem[coef_wr_addr] <= COEFF_WIDTH'(i_write_value);
        end
        if (i_cmd.coef_rd) begin
            r_cd <= r_coef_mem[coef_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= qse_pkg::KC_W'(qse_pkg::KC_RESET);
        end else if (i_cfg_wr_en) begin
            r_knot_count <= i_cfg_wr_data;
        end
    end

    assign res_max  = {1'b0, {(RW - 1){1'b1}}};
    assign res_min  = {1'b1, {(RW - 1){1'b0}}};
    assign coef48   = RW'(r_cd);
    assign coef_ext = SW'(coef48);
    assign five_c   = (coef_ext <<< 2) + coef_ext;
    assign five_fits = (&five_c[SW-1:RW-1]) || !(|five_c[SW-1:RW-1]);

    always_comb begin
        if (!r_slope) begin
            term = coef_ext;
        end else begin
            case (r_k)
                3'd2:    term = coef_ext <<< 1;
                3'd3:    term = (coef_ext <<< 1) + coef_ext;
                3'd4:    term = coef_ext <<< 2;
                default: term = coef_ext;
            endcase
        end
    end

    // one 24 x 33 multiplier, used for the low then the high half of |acc|
    assign mul_a = i_cmd.mul_hi ? r_amag[RW-1:HW] : r_amag[HW-1:0];
    assign prod  = PP_W'(mul_a) * PP_W'(r_dmag);

    assign full     = SUM_W'(r_pp_lo) + (SUM_W'(r_pp_hi) << HW) + RND_BIAS;
    assign shifted  = full[SUM_W-1:qse_pkg::FRAC_SHIFT];
    assign limit    = {{(SH_W - RW){1'b0}}, r_neg, {(RW - 1){~r_neg}}};
    assign mul_over = shifted > limit;

    assign sum      = r_neg ? r_term - SW'(r_pmag) : r_term + SW'(r_pmag);
    assign sum_fits = (&sum[SW-1:RW-1]) || !(|sum[SW-1:RW-1]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_x     <= i_query_x;
            r_slope <= (i_action == qse_pkg::ACT_SLOPE);
        end
        if (i_cmd.init_bounds) begin
            r_lo <= '0;
            r_hi <= last_idx;
        end
        if (i_cmd.set_mid) begin
            r_mid <= mid;
        end
        if (i_cmd.update_bounds) begin
            if (r_kd > r_x) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid;
            end
        end
        if (i_cmd.set_seg) begin
            r_k <= SELW'(qse_pkg::TOP_COEFF);
            case (i_cmd.seg_sel)
                qse_pkg::SEG_ZERO: r_seg <= '0;
                qse_pkg::SEG_LAST: r_seg <= last_idx - KW'(1);
                qse_pkg::SEG_LO:   r_seg <= r_lo;
                default:           r_seg <= r_lo;
            endcase
        end
        if (i_cmd.init_acc) begin
            r_d <= DW'(r_x) - DW'(r_kd);
            if (!r_slope) begin
                r_acc  <= coef48;
                r_flag <= 1'b0;
            end else if (five_fits) begin
                r_acc  <= five_c[RW-1:0];
                r_flag <= 1'b0;
            end else begin
                r_acc  <= five_c[SW-1] ? res_min : res_max;
                r_flag <= 1'b1;
            end
        end
        if (i_cmd.dec_k) begin
            r_k <= r_k - SELW'(1);
        end
        if (i_cmd.mag) begin
            r_amag <= r_acc[RW-1] ? RW'(~r_acc) + RW'(1) : RW'(r_acc);
            r_dmag <= r_d[DW-1] ? DW'(~r_d) + DW'(1) : DW'(r_d);
            r_neg  <= r_acc[RW-1] ^ r_d[DW-1];
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo <= prod;
        end
        if (i_cmd.mul_hi) begin
            r_pp_hi <= prod;
        end
        if (i_cmd.rnd) begin
            r_term <= term;
            r_pmag <= mul_over ? limit[RW-1:0] : shifted[RW-1:0];
            if (mul_over) begin
                r_flag <= 1'b1;
            end
        end
        if (i_cmd.add) begin
            if (sum_fits) begin
                r_acc <= sum[RW-1:0];
            end else begin
                r_acc  <= sum[SW-1] ? res_min : res_max;
                r_flag <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            o_result_value <= r_acc;
            o_segment      <= IW'(r_seg);
            o_saturated    <= r_flag;
        end
    end

    assign o_sts.x_le_kd   = r_x <= r_kd;
    assign o_sts.x_ge_kd   = r_x >= r_kd;
    assign o_sts.span_gt1  = ((KW + 1)'(r_hi) - (KW + 1)'(r_lo)) > (KW + 1)'(1);
    assign o_sts.last_step = r_slope ? (r_k == SELW'(1)) : (r_k == SELW'(0));

endmodule

/* src/qse_ctrl.sv */
module qse_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [qse_pkg::ACT_W-1:0] i_action,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  qse_pkg::t_dp_sts          i_sts,
    output qse_pkg::t_dp_cmd          o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RD_FIRST  = 4'd1;
    localparam logic [3:0] S_CMP_FIRST = 4'd2;
    localparam logic [3:0] S_CMP_LAST  = 4'd3;
    localparam logic [3:0] S_PROBE     = 4'd4;
    localparam logic [3:0] S_PCMP      = 4'd5;
    localparam logic [3:0] S_RD_SEG    = 4'd6;
    localparam logic [3:0] S_SETUP     = 4'd7;
    localparam logic [3:0] S_MAG       = 4'd8;
    localparam logic [3:0] S_MUL_LO    = 4'd9;
    localparam logic [3:0] S_MUL_HI    = 4'd10;
    localparam logic [3:0] S_RND       = 4'd11;
    localparam logic [3:0] S_ADD       = 4'd12;
    localparam logic [3:0] S_FIN       = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       is_write;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign is_write    = (i_action == qse_pkg::ACT_WR_KNOT) ||
                         (i_action == qse_pkg::ACT_WR_COEF);

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_write) begin
                        o_cmd.wr_knot = (i_action == qse_pkg::ACT_WR_KNOT);
                        o_cmd.wr_coef = (i_action == qse_pkg::ACT_WR_COEF);
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_RD_FIRST;
                    end
                end
            end
            S_RD_FIRST: begin
                o_cmd.knot_rd   = 1'b1;
                o_cmd.knot_addr = qse_pkg::KA_FIRST;
                n_state         = S_CMP_FIRST;
            end
            S_CMP_FIRST: begin
                // fetch the last knot while the first is compared
                o_cmd.knot_rd   = 1'b1;
                o_cmd.knot_addr = qse_pkg::KA_LAST;
                if (i_sts.x_le_kd) begin
                    o_cmd.set_seg = 1'b1;
                    o_cmd.seg_sel = qse_pkg::SEG_ZERO;
                    n_state       = S_RD_SEG;
                end else begin
                    n_state = S_CMP_LAST;
                end
            end
            S_CMP_LAST: begin
                if (i_sts.x_ge_kd) begin
                    o_cmd.set_seg = 1'b1;
                    o_cmd.seg_sel = qse_pkg::SEG_LAST;
                    n_state       = S_RD_SEG;
                end else begin
                    o_cmd.init_bounds = 1'b1;
                    n_state           = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.span_gt1) begin
                    o_cmd.knot_rd   = 1'b1;
                    o_cmd.knot_addr = qse_pkg::KA_MID;
                    o_cmd.set_mid   = 1'b1;
                    n_state         = S_PCMP;
                end else begin
                    o_cmd.set_seg = 1'b1;
                    o_cmd.seg_sel = qse_pkg::SEG_LO;
                    n_state       = S_RD_SEG;
                end
            end
            S_PCMP: begin
                o_cmd.update_bounds = 1'b1;
                n_state             = S_PROBE;
            end
            S_RD_SEG: begin
                o_cmd.knot_rd   = 1'b1;
                o_cmd.knot_addr = qse_pkg::KA_SEG;
                o_cmd.coef_rd   = 1'b1;
                n_state         = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.init_acc = 1'b1;
                o_cmd.dec_k    = 1'b1;
                n_state        = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag     = 1'b1;
                o_cmd.coef_rd = 1'b1;
                n_state       = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add   = 1'b1;
                o_cmd.dec_k = 1'b1;
                n_state     = i_sts.last_step ? S_FIN : S_MAG;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* src/quintic_spline_evaluate.sv */
// Piecewise quintic spline evaluator. Write items (knot or coefficient) are taken in the idle
// state and give no result. A query item runs one at a time: a segment search through the
// single knot-memory read port (the first and last knots, then binary-search probes, up to
// log2(knot_count-1) probes, 6 at 64 knots), a fetch of the segment and set-up, then Horner
// steps on the shared 24 x 33 multiplier (5 steps for a value, 4 for a slope), and last a load
// of the output register. The next item is accepted while a result waits in the output
// register. knot_count is clamped to 2..MAX_KNOTS; the user must write it only while the
// block is idle, and the block itself leaves this unenforced.
module quintic_spline_evaluate #(
    parameter int MAX_KNOTS   = qse_pkg::MAX_KNOTS_DEF,
    parameter int COEFF_WIDTH = qse_pkg::COEFF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [qse_pkg::ACT_W-1:0]         i_action,
    input  logic [qse_pkg::IDX_W-1:0]         i_entry_index,
    input  logic [qse_pkg::SEL_W-1:0]         i_coeff_sel,
    input  logic signed [qse_pkg::RES_W-1:0]  i_write_value,
    input  logic signed [qse_pkg::KNOT_W-1:0] i_query_x,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [qse_pkg::RES_W-1:0]  o_result_value,
    output logic [qse_pkg::IDX_W-1:0]         o_segment,
    output logic                              o_saturated,
    input  logic                              i_cfg_wr_en,
    input  logic [qse_pkg::KC_W-1:0]          i_cfg_wr_data
);

    qse_pkg::t_dp_cmd cmd;
    qse_pkg::t_dp_sts sts;

    qse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    qse_datapath #(
        .MAX_KNOTS   (MAX_KNOTS),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_coeff_sel    (i_coeff_sel),
        .i_write_value  (i_write_value),
        .i_query_x      (i_query_x),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_value (o_result_value),
        .o_segment      (o_segment),
        .o_saturated    (o_saturated)
    );

`ifndef SYNTHESIS
    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten");

    // a query item blocks further input until its result is loaded
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         (i_action == qse_pkg::ACT_VALUE || i_action == qse_pkg::ACT_SLOPE))
        |=> !o_in_ready)
        else $error("input accepted during a query");

    // a write item raises no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid &&
         (i_action == qse_pkg::ACT_WR_KNOT || i_action == qse_pkg::ACT_WR_COEF))
        |=> !o_out_valid)
        else $error("write item produced a result");
`endif

endmodule
